// ----- rtl/aht_pkg.sv -----
package aht_pkg;

    localparam int unsigned KEY_W   = 64;
    localparam int unsigned MOVE_W  = 32;
    localparam int unsigned SCORE_W = 32;
    localparam int unsigned AGE_W   = 8;
    localparam int unsigned OP_W    = 3;

    localparam logic [SCORE_W-1:0] DEPTH_MASK = 32'hfffc0000;

    typedef enum logic [OP_W-1:0] {
        OP_STORE_MOVE  = 3'd0,
        OP_READ_MOVE   = 3'd1,
        OP_REMOVE      = 3'd2,
        OP_STORE_VALUE = 3'd3,
        OP_READ_VALUE  = 3'd4,
        OP_ADVANCE_AGE = 3'd5,
        OP_CLEAR_VALUE = 3'd6,
        OP_NOP         = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EVAL,
        ST_SWEEP,
        ST_DONE
    } t_state;

    // Key, move and age share one memory word; the value lives apart so that
    // clearing all values is a write-only sweep.
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [MOVE_W-1:0] move;
        logic [AGE_W-1:0]  age;
    } t_entry;

    localparam int unsigned ENTRY_W = KEY_W + MOVE_W + AGE_W;

endpackage

// ----- rtl/aht_ram.sv -----
module aht_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/aged_hash_table_probe_unit.sv -----
// Keyed table with age-based replacement. One item is taken at a time: the
// beat is accepted, then the probe reads one slot per cycle from the table
// memory (registered read) until it settles, writes the slot back in that
// same cycle and then hands the result to the output register from ST_DONE,
// waiting there while the output beat is stalled. Advance age and no-op items
// skip the probe and go straight to ST_DONE. Clear values sweeps the value
// memory, one entry per cycle, before its result is handed out. After reset
// the block runs a clearing pass over every entry of both memories with
// s_axis_tready low; configuration writes are taken at all times.
// TABLE_ENTRIES must be a power of two, so the slot index is the low bits of
// the (shifted) key.
module aged_hash_table_probe_unit #(
    parameter int unsigned TABLE_ENTRIES = 65536
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // slave side
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // key[63:0], move_word[95:64], score[127:96]
    input  logic [2:0]   s_axis_tuser,  // op[2:0]
    // master side
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata,  // move_out[31:0], score_out[63:32]
    // move mask register
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [31:0]  i_cfg_data
);

    localparam int unsigned AW = $clog2(TABLE_ENTRIES);

    aht_pkg::t_state r_state, n_state;
    logic [AW-1:0]   r_ptr, n_ptr;
    logic [7:0]      r_age, n_age;
    logic [31:0]     r_mask;
    logic            r_out_valid;
    logic [63:0]     r_out_data;

    logic [63:0]     r_key, r_h, n_h;
    logic            r_first, n_first;
    aht_pkg::t_op    r_op;
    logic [31:0]     r_mv, r_sc;
    logic [31:0]     r_move_out, n_move_out;
    logic [31:0]     r_score_out, n_score_out;

    logic                  s_acc;
    aht_pkg::t_op          in_op;
    logic [AW-1:0]         rd_addr, wr_addr, slot;
    logic                  main_we, val_we;
    aht_pkg::t_entry       rd_e, wr_e;
    logic [aht_pkg::ENTRY_W-1:0] main_rdata;
    logic [31:0]           rd_val, wr_val;
    logic                  stale, empty, key_hit, taken, evict, nz;
    logic                  out_load;

    aht_ram #(.WIDTH(aht_pkg::ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_main_ram (
        .i_clk   (i_clk),
        .i_we    (main_we),
        .i_waddr (wr_addr),
        .i_wdata (wr_e),
        .i_raddr (rd_addr),
        .o_rdata (main_rdata)
    );

    aht_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES)) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (wr_addr),
        .i_wdata (wr_val),
        .i_raddr (rd_addr),
        .o_rdata (rd_val)
    );

    assign s_axis_tready = (r_state == aht_pkg::ST_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign in_op         = aht_pkg::t_op'(s_axis_tuser);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign out_load      = (r_state == aht_pkg::ST_DONE) && (!r_out_valid || m_axis_tready);

    assign rd_e    = aht_pkg::t_entry'(main_rdata);
    assign slot    = r_h[AW-1:0];
    assign stale   = (rd_e.age != r_age);
    assign empty   = (rd_e.key == '0);
    assign key_hit = (rd_e.key == r_key);
    assign nz      = (slot != '0);
    // the first slot is taken when empty before its age is looked at
    assign taken   = r_first ? (empty || stale || key_hit)
                             : (stale || key_hit || empty || !nz);
    assign evict   = stale && !(r_first && empty);

    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_age       = r_age;
        n_h         = r_h;
        n_first     = r_first;
        n_move_out  = r_move_out;
        n_score_out = r_score_out;
        rd_addr     = s_axis_tdata[AW-1:0];
        wr_addr     = r_ptr;
        main_we     = 1'b0;
        val_we      = 1'b0;
        wr_e        = '0;
        wr_val      = '0;

        unique case (r_state)
            aht_pkg::ST_CLEAR: begin
                main_we = 1'b1;
                val_we  = 1'b1;
                n_ptr   = r_ptr + 1'b1;
                if (r_ptr == '1) begin
                    n_state = aht_pkg::ST_IDLE;
                end
            end
            aht_pkg::ST_IDLE: begin
                if (s_acc) begin
                    n_move_out  = '0;
                    n_score_out = '0;
                    n_h         = s_axis_tdata[63:0];
                    n_first     = 1'b1;
                    n_ptr       = '0;
                    unique case (in_op)
                        aht_pkg::OP_STORE_MOVE, aht_pkg::OP_READ_MOVE, aht_pkg::OP_REMOVE,
                        aht_pkg::OP_STORE_VALUE, aht_pkg::OP_READ_VALUE: begin
                            n_state = aht_pkg::ST_EVAL;
                        end
                        aht_pkg::OP_ADVANCE_AGE: begin
                            n_age   = r_age + 1'b1;
                            n_state = aht_pkg::ST_DONE;
                        end
                        aht_pkg::OP_CLEAR_VALUE: begin
                            n_state = aht_pkg::ST_SWEEP;
                        end
                        default: begin
                            n_state = aht_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            aht_pkg::ST_EVAL: begin
                rd_addr = n_h[AW-1:0];
                wr_addr = slot;
                if (taken) begin
                    wr_e   = rd_e;
                    wr_val = rd_val;
                    if (evict) begin
                        wr_e.key = '0;
                        wr_e.age = '0;
                        wr_val   = '0;
                    end
                    unique case (r_op)
                        aht_pkg::OP_STORE_MOVE: begin
                            if (nz) begin
                                wr_e.move = r_mv & r_mask;
                                wr_e.key  = r_key;
                            end
                        end
                        aht_pkg::OP_READ_MOVE: begin
                            if (nz) begin
                                n_move_out = wr_e.move;
                            end
                        end
                        aht_pkg::OP_REMOVE: begin
                            if (nz) begin
                                wr_e.key  = '0;
                                wr_e.move = '0;
                            end
                        end
                        aht_pkg::OP_STORE_VALUE: begin
                            if (nz && ((r_sc & aht_pkg::DEPTH_MASK) >=
                                       (wr_val & aht_pkg::DEPTH_MASK))) begin
                                wr_e.key = r_key;
                                wr_e.age = r_age;
                                wr_val   = r_sc;
                            end
                        end
                        default: begin
                            if (wr_e.key == r_key) begin
                                n_score_out = wr_val;
                            end
                        end
                    endcase
                    main_we = 1'b1;
                    val_we  = 1'b1;
                    n_state = aht_pkg::ST_DONE;
                end else begin
                    // advance to the next slot of the chain
                    n_h     = r_h >> 1;
                    n_first = 1'b0;
                    rd_addr = n_h[AW-1:0];
                end
            end
            aht_pkg::ST_SWEEP: begin
                val_we = 1'b1;
                n_ptr  = r_ptr + 1'b1;
                if (r_ptr == '1) begin
                    n_state = aht_pkg::ST_DONE;
                end
            end
            aht_pkg::ST_DONE: begin
                if (out_load) begin
                    n_state = aht_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = aht_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= aht_pkg::ST_CLEAR;
            r_ptr       <= '0;
            r_age       <= '0;
            r_mask      <= '1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_age   <= n_age;
            if (i_cfg_valid && o_cfg_ready) begin
                r_mask <= i_cfg_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_h         <= n_h;
        r_first     <= n_first;
        r_move_out  <= n_move_out;
        r_score_out <= n_score_out;
        if (s_acc) begin
            r_op  <= in_op;
            r_key <= s_axis_tdata[63:0];
            r_mv  <= s_axis_tdata[95:64];
            r_sc  <= s_axis_tdata[127:96];
        end
        if (out_load) begin
            r_out_data <= {r_score_out, r_move_out};
        end
    end

endmodule

// ----- rtl/aht_checker.sv -----
module aht_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [63:0]  m_axis_tdata,
    input logic         o_cfg_ready
);

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // one item at a time: no beat taken in the cycle after an accepted one
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted on consecutive cycles");

    // only one op answers a move and only one answers a value
    a_one_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[31:0] == '0) || (m_axis_tdata[63:32] == '0))
        else $error("move and value both non-zero in one result");

    // no new result beat appears while the block is still ready for input
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared with no item in flight");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("configuration port refused a write");

endmodule

bind aged_hash_table_probe_unit aht_checker u_aht_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .o_cfg_ready   (o_cfg_ready)
);

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;

    localparam int unsigned ENTRIES = 65536;
    localparam int unsigned SLOT_W  = 16;
    localparam int unsigned LIMIT   = 4000000;
    localparam int unsigned N_RAND  = 1250;

    typedef struct {
        aht_pkg::t_op op;
        logic [63:0]  key;
        logic [31:0]  mv;
        logic [31:0]  sc;
        bit           typed;
        logic [31:0]  move_exp;
        logic [31:0]  score_exp;
    } t_row;

    typedef struct {
        logic [31:0] move_res;
        logic [31:0] score_res;
    } t_res;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic [2:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [63:0]  m_axis_tdata;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [31:0]  i_cfg_data;

    aged_hash_table_probe_unit #(.TABLE_ENTRIES(ENTRIES)) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // table model, sparse: a missing slot reads as all zero
    logic [63:0] key_tab[int unsigned];
    logic [31:0] move_tab[int unsigned];
    logic [31:0] value_tab[int unsigned];
    logic [7:0]  age_tab[int unsigned];
    logic [7:0]  age_now;
    logic [31:0] mask_now;

    t_res        result_q[$];
    int unsigned fail_cnt;
    int unsigned cycle_cnt;
    bit          idle_off;
    logic [63:0] key_pool[24];

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    function automatic logic [63:0] key_at(int unsigned s);
        return key_tab.exists(s) ? key_tab[s] : '0;
    endfunction

    function automatic logic [7:0] age_at(int unsigned s);
        return age_tab.exists(s) ? age_tab[s] : '0;
    endfunction

    function automatic logic [31:0] value_at(int unsigned s);
        return value_tab.exists(s) ? value_tab[s] : '0;
    endfunction

    function automatic void evict_slot(int unsigned s);
        key_tab[s]   = '0;
        value_tab[s] = '0;
        age_tab[s]   = '0;
    endfunction

    function automatic int unsigned find_slot(logic [63:0] key);
        logic [63:0] h;
        int unsigned s;
        h = key;
        s = 32'(h[SLOT_W-1:0]);
        if (key_at(s) == '0)
            return s;
        if (age_at(s) != age_now) begin
            evict_slot(s);
            return s;
        end
        if (key_at(s) == key)
            return s;
        do begin
            h = h >> 1;
            s = 32'(h[SLOT_W-1:0]);
            if (age_at(s) != age_now) begin
                evict_slot(s);
                return s;
            end
        end while (key_at(s) != key && key_at(s) != '0 && s != 0);
        return s;
    endfunction

    function automatic t_res apply_item(aht_pkg::t_op op, logic [63:0] key, logic [31:0] mv,
                                        logic [31:0] sc);
        t_res r;
        int unsigned s;
        r.move_res  = '0;
        r.score_res = '0;
        case (op)
            aht_pkg::OP_STORE_MOVE: begin
                s = find_slot(key);
                if (s != 0) begin
                    move_tab[s] = mv & mask_now;
                    key_tab[s]  = key;
                end
            end
            aht_pkg::OP_READ_MOVE: begin
                s = find_slot(key);
                if (s != 0 && move_tab.exists(s))
                    r.move_res = move_tab[s];
            end
            aht_pkg::OP_REMOVE: begin
                s = find_slot(key);
                if (s != 0) begin
                    key_tab[s]  = '0;
                    move_tab[s] = '0;
                end
            end
            aht_pkg::OP_STORE_VALUE: begin
                s = find_slot(key);
                if (s != 0 && (sc & aht_pkg::DEPTH_MASK) >=
                              (value_at(s) & aht_pkg::DEPTH_MASK)) begin
                    key_tab[s]   = key;
                    value_tab[s] = sc;
                    age_tab[s]   = age_now;
                end
            end
            aht_pkg::OP_READ_VALUE: begin
                s = find_slot(key);
                if (key_at(s) == key)
                    r.score_res = value_at(s);
            end
            aht_pkg::OP_ADVANCE_AGE: age_now = age_now + 8'd1;
            aht_pkg::OP_CLEAR_VALUE: value_tab.delete();
            default: ;
        endcase
        return r;
    endfunction

    // sender: random gaps unless a no-gap stretch is running
    task automatic send_item(aht_pkg::t_op op, logic [63:0] key, logic [31:0] mv,
                             logic [31:0] sc, bit typed, logic [31:0] move_exp,
                             logic [31:0] score_exp);
        t_res r;
        while (!idle_off && $urandom_range(99) < 20) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tdata  = {sc, mv, key};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        r = apply_item(op, key, mv, sc);
        if (typed) begin
            r.move_res  = move_exp;
            r.score_res = score_exp;
        end
        result_q.push_back(r);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic write_mask(logic [31:0] m);
        while (result_q.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = m;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        mask_now = m;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic void fill_pool();
        logic [63:0] base;
        base = {$urandom, $urandom};
        for (int i = 0; i < 24; i++) begin
            case (i % 6)
                0: key_pool[i] = {$urandom, $urandom};
                // same first slot as base, chains through shifted slots
                1, 2: key_pool[i] = {20'($urandom_range(15)), base[43:0]};
                // small keys walk down to slot 0
                3: key_pool[i] = 64'($urandom_range(200));
                4: key_pool[i] = {$urandom, $urandom} & 64'h0000_0000_0003_ffff;
                default: key_pool[i] = {$urandom, $urandom} | 64'h8000_0000_0000_0000;
            endcase
        end
        key_pool[23] = '0;
    endfunction

    task automatic random_phase(int unsigned n);
        int unsigned pick;
        aht_pkg::t_op op;
        logic [63:0] key;
        logic [31:0] sc;
        fill_pool();
        for (int unsigned i = 0; i < n; i++) begin
            idle_off = (i >= n / 2 && i < n / 2 + 60);
            pick = $urandom_range(999);
            if      (pick < 200) op = aht_pkg::OP_STORE_MOVE;
            else if (pick < 380) op = aht_pkg::OP_READ_MOVE;
            else if (pick < 460) op = aht_pkg::OP_REMOVE;
            else if (pick < 660) op = aht_pkg::OP_STORE_VALUE;
            else if (pick < 870) op = aht_pkg::OP_READ_VALUE;
            else if (pick < 975) op = aht_pkg::OP_ADVANCE_AGE;
            else if (pick < 978) op = aht_pkg::OP_CLEAR_VALUE;
            else                 op = aht_pkg::OP_NOP;
            key = ($urandom_range(9) == 0) ? {$urandom, $urandom}
                                           : key_pool[$urandom_range(23)];
            sc = $urandom;
            if ($urandom_range(1)) sc[31:18] = 14'($urandom_range(3));
            send_item(op, key, $urandom, sc, 1'b0, '0, '0);
        end
        idle_off = 1'b0;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_res e;
        if (m_axis_tvalid && m_axis_tready) begin
            if (result_q.size() == 0) begin
                $error("result beat with nothing expected: %h", m_axis_tdata);
                fail_cnt++;
            end else begin
                e = result_q.pop_front();
                if (m_axis_tdata[31:0] !== e.move_res) begin
                    $error("move_out: expected %h, got %h", e.move_res, m_axis_tdata[31:0]);
                    fail_cnt++;
                end
                if (m_axis_tdata[63:32] !== e.score_res) begin
                    $error("score_out: expected %0d, got %0d",
                           $signed(e.score_res), $signed(m_axis_tdata[63:32]));
                    fail_cnt++;
                end
            end
        end
    end

    // receiver stalls
    always @(negedge i_clk) begin
        if (!i_rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= idle_off || ($urandom_range(99) >= 20);
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT) begin
            $display("[aged_hash_table_probe_unit] ERROR");
            $finish;
        end
    end

    initial begin
        t_row rows[$];
        int unsigned per_phase;
        logic [63:0] ones;
        ones = '1;
        rows = '{
            '{aht_pkg::OP_READ_MOVE,   64'd5,      '0, '0, 1'b1, '0, '0},
            '{aht_pkg::OP_READ_VALUE,  '0,         '0, '0, 1'b1, '0, '0},
            '{aht_pkg::OP_NOP,         ones,       '1, '1, 1'b1, '0, '0},
            '{aht_pkg::OP_STORE_MOVE,  64'h1_0000, 32'h1234_5678, '0, 1'b1, '0, '0},
            '{aht_pkg::OP_READ_MOVE,   64'h1_0000, '0, '0, 1'b1, '0, '0},
            '{aht_pkg::OP_STORE_MOVE,  ones,       '1, '0, 1'b1, '0, '0},
            '{aht_pkg::OP_READ_MOVE,   ones,       '0, '0, 1'b0, '0, '0},
            '{aht_pkg::OP_STORE_VALUE, ones,       '0, 32'h7fff_ffff, 1'b1, '0, '0},
            '{aht_pkg::OP_READ_VALUE,  ones,       '0, '0, 1'b0, '0, '0},
            '{aht_pkg::OP_STORE_VALUE, ones,       '0, 32'h8000_0000, 1'b1, '0, '0},
            '{aht_pkg::OP_READ_VALUE,  ones,       '0, '0, 1'b0, '0, '0},
            '{aht_pkg::OP_STORE_VALUE, ones,       '0, '0, 1'b1, '0, '0},
            '{aht_pkg::OP_READ_VALUE,  ones,       '0, '0, 1'b0, '0, '0},
            '{aht_pkg::OP_STORE_MOVE,  64'h2_ffff, 32'hdead_beef, '0, 1'b1, '0, '0},
            '{aht_pkg::OP_READ_MOVE,   64'h2_ffff, '0, '0, 1'b0, '0, '0},
            '{aht_pkg::OP_ADVANCE_AGE, '0,         '0, '0, 1'b1, '0, '0},
            '{aht_pkg::OP_READ_VALUE,  ones,       '0, '0, 1'b0, '0, '0},
            '{aht_pkg::OP_REMOVE,      64'h2_ffff, '0, '0, 1'b1, '0, '0},
            '{aht_pkg::OP_READ_MOVE,   64'h2_ffff, '0, '0, 1'b0, '0, '0},
            '{aht_pkg::OP_STORE_VALUE, '0,         '0, 32'h0004_0000, 1'b1, '0, '0},
            '{aht_pkg::OP_READ_VALUE,  '0,         '0, '0, 1'b0, '0, '0},
            '{aht_pkg::OP_CLEAR_VALUE, '0,         '0, '0, 1'b1, '0, '0},
            '{aht_pkg::OP_READ_MOVE,   64'h8000_0000_0000_0001, '0, '0, 1'b0, '0, '0}
        };
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = aht_pkg::OP_NOP;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        m_axis_tready = 1'b0;
        fail_cnt      = 0;
        cycle_cnt     = 0;
        idle_off      = 1'b0;
        age_now       = '0;
        mask_now      = '1;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (rows[i])
            send_item(rows[i].op, rows[i].key, rows[i].mv, rows[i].sc,
                      rows[i].typed, rows[i].move_exp, rows[i].score_exp);

        per_phase = N_RAND / 5;
        random_phase(per_phase);
        write_mask('0);
        random_phase(per_phase);
        write_mask(32'h0000_ffff);
        random_phase(per_phase);
        write_mask($urandom);
        random_phase(per_phase);
        write_mask('1);
        random_phase(per_phase);

        while (result_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("[aged_hash_table_probe_unit] OK");
        else
            $display("[aged_hash_table_probe_unit] ERROR");
        $finish;
    end

endmodule
